### rtl/core/msg_client_connection_reassembler_macros.svh
// Assertion macros shared by the connection reassembler RTL.
`ifndef MSG_CLIENT_CONNECTION_REASSEMBLER_MACROS_SVH
`define MSG_CLIENT_CONNECTION_REASSEMBLER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MCCR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a signal holds in the cycle after a condition.
`define MCCR_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

### rtl/core/mccr_pkg.sv
// Shared types and codes of the message client connection reassembler.
package mccr_pkg;

  localparam logic [7:0] DYN_ADDR_BASE = 8'h20;

  localparam logic [2:0] FN_DATA       = 3'd0;
  localparam logic [2:0] FN_CONNECT    = 3'd1;
  localparam logic [2:0] FN_DISCONNECT = 3'd2;
  localparam logic [2:0] FN_HOST_CRED  = 3'd3;
  localparam logic [2:0] FN_TAKE_CRED  = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_ALREADY   = 3'd3;
  localparam logic [2:0] ST_NOT_CONN  = 3'd4;
  localparam logic [2:0] ST_NO_CREDIT = 3'd5;

  // Classified request as queued between front and back.
  typedef struct packed {
    logic [2:0] func;
    logic [7:0] idx;
    logic       idx_ok;
    logic [7:0] peer;
    logic [8:0] flen;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        payload_write;
    logic [11:0] write_offset;
    logic        deliver;
    logic [12:0] deliver_length;
    logic        send_credit_to_host;
    logic        send_reply;
  } res_t;

endpackage

### rtl/core/msg_client_connection_reassembler.sv
// Top level of the message client connection reassembler.
// Each request yields exactly one result, in order. A request waits in a two-entry input
// queue, then passes through the back end, which first reads the client's table entry from
// the memory and then updates it and emits the result. The back end takes no new request
// until the last one's result is pushed into the two-entry output queue, and it stalls while
// that queue is full; a result waits there until it is popped. The table comes out of reset
// empty at once through per-entry valid bits, with no clearing pass. The client count
// register is written through the configuration channel, which is always ready; the user
// must write it only while no request is in flight, as the block itself does not enforce this.
module msg_client_connection_reassembler #(
  parameter int MAX_CLIENTS   = 32,
  parameter int MAX_MSG_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  func_i,
  input  logic [7:0]  client_addr_i,
  input  logic [7:0]  peer_addr_i,
  input  logic [8:0]  frag_len_i,
  input  logic        frag_last_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic        payload_write_o,
  output logic [11:0] write_offset_o,
  output logic        deliver_o,
  output logic [12:0] deliver_length_o,
  output logic        send_credit_to_host_o,
  output logic        send_reply_o
);
  import mccr_pkg::*;

  logic [5:0]              registered_clients_q;
  cmd_t                    cmd;
  logic                    cmd_empty, cmd_pop;
  res_t                    res, res_head;
  logic                    res_push, res_full;
  logic [$bits(res_t)-1:0] res_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      registered_clients_q <= 6'd0;
    end else if (cfg_valid_i) begin
      registered_clients_q <= cfg_data_i;
    end
  end

  mccr_front #(
    .MAX_CLIENTS(MAX_CLIENTS)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .registered_clients_i(registered_clients_q),
    .push_i              (push),
    .full_o              (full),
    .func_i              (func_i),
    .client_addr_i       (client_addr_i),
    .peer_addr_i         (peer_addr_i),
    .frag_len_i          (frag_len_i),
    .frag_last_i         (frag_last_i),
    .cmd_pop_i           (cmd_pop),
    .cmd_o               (cmd),
    .cmd_empty_o         (cmd_empty)
  );

  mccr_back #(
    .MAX_CLIENTS  (MAX_CLIENTS),
    .MAX_MSG_BYTES(MAX_MSG_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_o      (res),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  mccr_fifo #(
    .W($bits(res_t))
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_rdata),
    .empty_o(empty)
  );

  assign res_head              = res_t'(res_rdata);
  assign status_o              = res_head.status;
  assign payload_write_o       = res_head.payload_write;
  assign write_offset_o        = res_head.write_offset;
  assign deliver_o             = res_head.deliver;
  assign deliver_length_o      = res_head.deliver_length;
  assign send_credit_to_host_o = res_head.send_credit_to_host;
  assign send_reply_o          = res_head.send_reply;

endmodule

### rtl/core/mccr_fifo.sv
// Two-entry first-in first-out queue of packed words.
module mccr_fifo #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

endmodule

### rtl/core/mccr_front.sv
// Front end: decodes the client index, checks it and queues the request.
module mccr_front #(
  parameter int MAX_CLIENTS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [5:0]     registered_clients_i,
  input  logic           push_i,
  output logic           full_o,
  input  logic [2:0]     func_i,
  input  logic [7:0]     client_addr_i,
  input  logic [7:0]     peer_addr_i,
  input  logic [8:0]     frag_len_i,
  input  logic           frag_last_i,
  input  logic           cmd_pop_i,
  output mccr_pkg::cmd_t cmd_o,
  output logic           cmd_empty_o
);
  import mccr_pkg::*;

  localparam logic [7:0] MaxCnt = 8'(MAX_CLIENTS);

  logic [7:0]              idx;
  logic [7:0]              cnt;
  logic                    ok;
  cmd_t                    cmd;
  logic [$bits(cmd_t)-1:0] rdata;

  always_comb begin
    idx = client_addr_i - DYN_ADDR_BASE;
    cnt = ({2'b00, registered_clients_i} > MaxCnt) ? MaxCnt : {2'b00, registered_clients_i};
    ok  = (idx < cnt);
    cmd.func   = func_i;
    // park the table address at entry zero for an out-of-range client
    cmd.idx    = ok ? idx : 8'd0;
    cmd.idx_ok = ok;
    cmd.peer   = peer_addr_i;
    cmd.flen   = frag_len_i;
    cmd.last   = frag_last_i;
  end

  mccr_fifo #(
    .W($bits(cmd_t))
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .wdata_i(cmd),
    .full_o (full_o),
    .pop_i  (cmd_pop_i),
    .rdata_o(rdata),
    .empty_o(cmd_empty_o)
  );

  assign cmd_o = cmd_t'(rdata);

endmodule

### rtl/core/mccr_back.sv
// Back end: client table read-modify-write and result generation.
`include "msg_client_connection_reassembler_macros.svh"

module mccr_back #(
  parameter int MAX_CLIENTS   = 32,
  parameter int MAX_MSG_BYTES = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mccr_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output mccr_pkg::res_t res_o,
  output logic           res_push_o,
  input  logic           res_full_i
);
  import mccr_pkg::*;

  localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int LEN_W = $clog2(MAX_MSG_BYTES + 1);
  localparam logic [LEN_W:0] MaxLen = (LEN_W + 1)'(MAX_MSG_BYTES);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  cmd_t cmd_q;

  // table storage, one word per client
  logic             conn_mem  [MAX_CLIENTS];
  logic [7:0]       peer_mem  [MAX_CLIENTS];
  logic [LEN_W-1:0] len_mem   [MAX_CLIENTS];
  logic             disc_mem  [MAX_CLIENTS];
  logic             cred_mem  [MAX_CLIENTS];
  logic             ent_vld_q [MAX_CLIENTS];

  logic             vld_rd_q, conn_rd_q, disc_rd_q, cred_rd_q;
  logic [7:0]       peer_rd_q;
  logic [LEN_W-1:0] len_rd_q;

  logic             tbl_we;
  logic             conn_n, disc_n, cred_n;
  logic [7:0]       peer_n;
  logic [LEN_W-1:0] len_n;
  logic [IDX_W-1:0] rd_addr, wr_addr;

  logic             e_conn, e_disc, e_cred;
  logic [7:0]       e_peer;
  logic [LEN_W-1:0] e_len;
  logic [LEN_W:0]   sum;
  res_t             res;

  assign cmd_pop_o  = (state_q == S_IDLE) && !cmd_empty_i;
  assign res_push_o = (state_q == S_EXEC) && !res_full_i;
  assign rd_addr    = cmd_i.idx[IDX_W-1:0];
  assign wr_addr    = cmd_q.idx[IDX_W-1:0];
  assign res_o      = res;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (cmd_pop_o) state_d = S_EXEC;
      S_EXEC:  if (res_push_o) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // latch the request and read its table entry
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q     <= cmd_i;
      vld_rd_q  <= ent_vld_q[rd_addr];
      conn_rd_q <= conn_mem[rd_addr];
      peer_rd_q <= peer_mem[rd_addr];
      len_rd_q  <= len_mem[rd_addr];
      disc_rd_q <= disc_mem[rd_addr];
      cred_rd_q <= cred_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      conn_mem[wr_addr] <= conn_n;
      peer_mem[wr_addr] <= peer_n;
      len_mem[wr_addr]  <= len_n;
      disc_mem[wr_addr] <= disc_n;
      cred_mem[wr_addr] <= cred_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CLIENTS; i++) ent_vld_q[i] <= 1'b0;
    end else if (tbl_we) begin
      ent_vld_q[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    // an entry never written reads as all zero
    e_conn = vld_rd_q && conn_rd_q;
    e_disc = vld_rd_q && disc_rd_q;
    e_cred = vld_rd_q && cred_rd_q;
    e_peer = vld_rd_q ? peer_rd_q : 8'd0;
    e_len  = vld_rd_q ? len_rd_q : '0;
    sum    = {1'b0, e_len} + (LEN_W + 1)'(cmd_q.flen);

    conn_n = e_conn;
    peer_n = e_peer;
    len_n  = e_len;
    disc_n = e_disc;
    cred_n = e_cred;
    tbl_we = 1'b0;
    res    = '0;
    res.status = ST_OK;

    case (cmd_q.func)
      FN_DATA: begin
        if (!cmd_q.idx_ok) begin
          res.status = ST_NOT_FOUND;
        end else if (!e_conn) begin
          res.status = ST_NOT_CONN;
        end else if (e_peer != cmd_q.peer) begin
          res.status = ST_INVALID;
        end else begin
          tbl_we = 1'b1;
          disc_n = e_disc || (sum > MaxLen);
          if (!disc_n) begin
            res.payload_write = (cmd_q.flen != 9'd0);
            res.write_offset  = (cmd_q.flen != 9'd0) ? 12'(e_len) : 12'd0;
            len_n = sum[LEN_W-1:0];
          end else begin
            res.status = ST_NOT_CONN;
          end
          if (cmd_q.last) begin
            if (!disc_n) begin
              res.deliver        = 1'b1;
              res.deliver_length = 13'(len_n);
            end
            len_n = '0;
            disc_n = 1'b0;
            res.send_credit_to_host = 1'b1;
          end
        end
      end
      FN_CONNECT: begin
        res.send_reply = 1'b1;
        if (!cmd_q.idx_ok) begin
          res.status = ST_NOT_FOUND;
        end else if (cmd_q.peer == 8'd0) begin
          res.status = ST_INVALID;
        end else if (e_conn) begin
          res.status = ST_ALREADY;
        end else begin
          tbl_we = 1'b1;
          conn_n = 1'b1;
          peer_n = cmd_q.peer;
          res.send_credit_to_host = 1'b1;
        end
      end
      FN_DISCONNECT: begin
        res.send_reply = 1'b1;
        if (!cmd_q.idx_ok || !e_conn) begin
          res.status = ST_NOT_FOUND;
        end else if (e_peer != cmd_q.peer) begin
          res.status = ST_INVALID;
        end else begin
          tbl_we = 1'b1;
          conn_n = 1'b0;
        end
      end
      FN_HOST_CRED: begin
        if (!cmd_q.idx_ok) begin
          res.status = ST_NOT_FOUND;
        end else if (!e_conn) begin
          res.status = ST_NOT_CONN;
        end else begin
          tbl_we = 1'b1;
          cred_n = 1'b1;
        end
      end
      FN_TAKE_CRED: begin
        if (!cmd_q.idx_ok) begin
          res.status = ST_INVALID;
        end else if (!e_conn) begin
          res.status = ST_NOT_CONN;
        end else if (!e_cred) begin
          res.status = ST_NO_CREDIT;
        end else begin
          tbl_we = 1'b1;
          cred_n = 1'b0;
        end
      end
      default: res.status = ST_INVALID;
    endcase

    // commit only together with the result
    if (!res_push_o) tbl_we = 1'b0;
  end

  `MCCR_ASSERT(a_push_in_exec, clk_i, rst_ni, res_push_o |-> (state_q == S_EXEC), "result outside exec")
  `MCCR_ASSERT(a_pop_in_idle, clk_i, rst_ni, cmd_pop_o |-> (state_q == S_IDLE), "request taken while busy")
  `MCCR_ASSERT(a_pop_then_exec, clk_i, rst_ni, cmd_pop_o |=> (state_q == S_EXEC && !cmd_pop_o), "no exec after read")
  `MCCR_ASSERT_HOLD(a_cmd_held, clk_i, rst_ni, (state_q == S_EXEC && !res_push_o), cmd_q, "stalled request changed")

endmodule
